// ===== rtl/core/lru_key_value_cache_top_macros.svh =====
// assertion helpers for the lru key-value cache
`ifndef LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH
`define LRU_KEY_VALUE_CACHE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define LKVC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/lkvc_pkg.sv =====
`default_nettype none
package lkvc_pkg;

  localparam int KEY_W     = 32;
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 5;
  localparam int CAP_RESET = 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

  // one stored entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } kv_t;

endpackage
`default_nettype wire

// ===== rtl/core/lkvc_cell.sv =====
`default_nettype none
module lkvc_cell (
  input  wire logic                      clk,
  input  wire logic                      valid,
  input  wire logic                      shift_en,
  input  wire lkvc_pkg::kv_t             kv_in,
  input  wire logic [lkvc_pkg::KEY_W-1:0] cmp_key,
  output lkvc_pkg::kv_t                  kv_out,
  output logic                           match
);
  import lkvc_pkg::*;

  kv_t kv_r;

  // take the neighbor's entry when the list moves down
  always_ff @(posedge clk) begin
    if (shift_en) begin
      kv_r <= kv_in;
    end
  end

  assign kv_out = kv_r;
  assign match  = valid && (kv_r.key == cmp_key);

endmodule
`default_nettype wire

// ===== rtl/core/lru_key_value_cache_top.sv =====
`default_nettype none
`include "lru_key_value_cache_top_macros.svh"
// lru key-value cache, fully associative, least recently used entry goes first
//
// input: a beat is taken at a rising edge with start high and busy low;
//   in_op selects get or put, in_lookup_key is the key, in_store_value the
//   data for a put
// output: a get gives one beat on out_strobe, a single cycle wide, with
//   out_found and out_read_value (all ones on a miss); a put gives none
// config: cfg_write_en with cfg_write_data sets the capacity in use; zero
//   acts as one, values above ENTRIES act as ENTRIES; write only while idle
// sequence: no beat is taken while busy; taking a beat registers the match
//   of every cell, then the busy cycle shifts the list and loads the result,
//   so out_strobe is high in the cycle after busy and a new beat can be
//   taken in that same cycle
// structure: a row of cells kept in recency order, cell 0 newest; a hit at
//   position i moves cells 0..i-1 down one place and rewrites cell 0, a new
//   put moves the whole row down and drops whatever falls past the capacity
// reset: empty cache, capacity back to 16, no result pending; the receiver
//   cannot stall, every result is delivered in its cycle
module lru_key_value_cache_top #(
  parameter int ENTRIES = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              in_op,
  input  wire logic signed [lkvc_pkg::KEY_W-1:0] in_lookup_key,
  input  wire logic signed [lkvc_pkg::VAL_W-1:0] in_store_value,
  input  wire logic                              cfg_write_en,
  input  wire logic        [lkvc_pkg::CAP_W-1:0] cfg_write_data,
  output logic                                   out_strobe,
  output logic                                   out_found,
  output logic signed      [lkvc_pkg::VAL_W-1:0] out_read_value
);
  import lkvc_pkg::*;

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int LIM_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  // control and captured item
  logic [CAP_W-1:0] cap_r;
  logic [OCC_W-1:0] occ_r;
  logic [OCC_W-1:0] occ_nxt;
  logic             busy_r;
  logic             op_r;
  logic [KEY_W-1:0] key_r;
  logic [VAL_W-1:0] value_r;
  logic [ENTRIES-1:0] match_r;

  logic             out_strobe_r;
  logic             out_found_r;
  logic [VAL_W-1:0] out_read_value_r;

  logic accept;
  assign accept = start && !busy_r;

  // cell row
  kv_t              cell_kv [ENTRIES];
  logic [ENTRIES-1:0] cell_match;
  logic [ENTRIES-1:0] cell_shift;
  kv_t              front_kv;

  // hit lookup over the registered match vector
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic [VAL_W-1:0] hit_value;

  always_comb begin
    hit_idx   = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_r[i]) begin
        hit_idx   = hit_idx | IDX_W'(i);
        hit_value = hit_value | cell_kv[i].value;
      end
    end
  end

  assign hit = |match_r;

  // entry written at the head of the row
  assign front_kv.key   = key_r;
  assign front_kv.value = (op_r == OP_PUT) ? value_r : hit_value;

  // effective capacity
  logic [LIM_W-1:0] cap_ext;
  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] occ_ext;

  assign cap_ext = LIM_W'(cap_r);
  assign occ_ext = LIM_W'(occ_r);

  always_comb begin
    if (cap_ext == '0) begin
      lim = LIM_W'(1);
    end else if (cap_ext > LIM_W'(ENTRIES)) begin
      lim = LIM_W'(ENTRIES);
    end else begin
      lim = cap_ext;
    end
  end

  // a new key drops the tail down to one under the limit, then adds one
  always_comb begin
    occ_nxt = occ_r;
    if (busy_r && (op_r == OP_PUT) && !hit) begin
      if (occ_ext >= lim) begin
        occ_nxt = OCC_W'(lim);
      end else begin
        occ_nxt = occ_r + OCC_W'(1);
      end
    end
  end

  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    logic cell_valid;
    assign cell_valid = occ_r > OCC_W'(j);
    // a miss put moves the whole row, a hit moves the row up to the hit cell
    assign cell_shift[j] = busy_r &&
                           (((op_r == OP_PUT) && !hit) ||
                            (hit && (IDX_W'(j) <= hit_idx)));

    if (j == 0) begin : g_head
      lkvc_cell u_cell (
        .clk      (clk),
        .valid    (cell_valid),
        .shift_en (cell_shift[j]),
        .kv_in    (front_kv),
        .cmp_key  (in_lookup_key),
        .kv_out   (cell_kv[j]),
        .match    (cell_match[j])
      );
    end else begin : g_body
      lkvc_cell u_cell (
        .clk      (clk),
        .valid    (cell_valid),
        .shift_en (cell_shift[j]),
        .kv_in    (cell_kv[j-1]),
        .cmp_key  (in_lookup_key),
        .kv_out   (cell_kv[j]),
        .match    (cell_match[j])
      );
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_W'(CAP_RESET);
      occ_r        <= '0;
      busy_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        cap_r <= cfg_write_data;
      end
      occ_r        <= occ_nxt;
      busy_r       <= accept;
      out_strobe_r <= busy_r && (op_r == OP_GET);
    end
  end

  // captured beat and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_op;
      key_r   <= in_lookup_key;
      value_r <= in_store_value;
      match_r <= cell_match;
    end
    if (busy_r) begin
      out_found_r      <= hit;
      out_read_value_r <= hit ? hit_value : MISS_VALUE;
    end
  end

  assign busy           = busy_r;
  assign out_strobe     = out_strobe_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_read_value_r;

  // checks
  `LKVC_ASSERT_NOW(a_occ_bound, clk, rst_n, 1'b1, occ_r <= OCC_W'(ENTRIES), "occupancy past entries")
  `LKVC_ASSERT_NOW(a_one_hit, clk, rst_n, busy_r, $onehot0(match_r), "key stored in two cells")
  `LKVC_ASSERT_NOW(a_strobe_idle, clk, rst_n, out_strobe_r, !busy_r, "result while busy")
  `LKVC_ASSERT_NEXT(a_put_fills, clk, rst_n, busy_r && (op_r == OP_PUT), occ_r != '0, "put left cache empty")

endmodule
`default_nettype wire
